FILE: sv/wse_pkg.sv
// Package for the wheel speed estimator: payload structs, register indexes,
// controller states and the command/status bundles between control and datapath.
// No dependencies.
`default_nettype none

package wse_pkg;

  localparam int unsigned Wheels   = 4;
  localparam int unsigned AvgTaps  = 4;
  localparam int unsigned WheelW   = $clog2(Wheels);
  localparam int unsigned SlotW    = $clog2(AvgTaps);
  localparam int unsigned MsPerS   = 1000;
  localparam int unsigned MsW      = 10;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DIST_PER_TICK = 8'd0,
    CFG_RAMP_PERIOD   = 8'd1,
    CFG_RAMP_STEP     = 8'd2,
    CFG_DUTY_MAX      = 8'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [31:0] front_left_count;
    logic [31:0] front_right_count;
    logic [31:0] rear_left_count;
    logic [31:0] rear_right_count;
    logic [31:0] time_ms;
  } in_t;

  typedef struct packed {
    logic signed [31:0] front_left_speed;
    logic signed [31:0] front_right_speed;
    logic signed [31:0] rear_left_speed;
    logic signed [31:0] rear_right_speed;
    logic signed [31:0] vehicle_speed;
    logic [15:0]        duty_out;
    logic               div_zero;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_DIV,
    ST_WAIT,
    ST_STORE,
    ST_AVG,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic load;
    logic mul1;
    logic mul2;
    logic div_start;
    logic store;
    logic next_wheel;
    logic avg;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic zero;
    logic last_wheel;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

FILE: sv/wheel_speed_estimator_pwm_ramp.sv
// Wheel speed estimator with open-loop duty ramp: top level.
// Per wheel: two multiplies, a divide in the shared bit-serial divider (skipped at
// zero dt) and a store; then averaging and hand-off to the output register.
// A new sample is taken only when idle, but may be taken while a result waits.
// Reset: asynchronous, active low; history, previous counts and ramp cleared,
// configuration registers return to their defaults.
`default_nettype none

module wheel_speed_estimator_pwm_ramp
  import wse_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire in_t                 in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output out_t                     out_data_o,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready_o = 1'b1;

  wse_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  wse_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

FILE: sv/wse_div.sv
// Iterative unsigned 32-bit restoring divider, one quotient bit per cycle.
// Standalone; instantiated by the datapath.
`default_nettype none

module wse_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] dividend_i,
  input  wire logic [31:0] divisor_i,
  output logic             done_o,
  output logic [31:0]      quotient_o
);

  localparam int unsigned DivW = 32;
  localparam int unsigned CntW = $clog2(DivW + 1);

  logic [CntW-1:0] cnt_q;
  logic            done_q;
  logic [31:0]     rem_q, quo_q, div_q;
  logic [32:0]     shifted;
  logic [33:0]     diff;
  logic            ge;

  always_comb begin
    shifted = {rem_q, quo_q[31]};
    diff    = {1'b0, shifted} - {2'b00, div_q};
    ge      = !diff[33];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CntW'(DivW);
      end else if (cnt_q != '0) begin
        cnt_q  <= cnt_q - CntW'(1);
        done_q <= (cnt_q == CntW'(1));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      div_q <= divisor_i;
    end else if (cnt_q != '0) begin
      rem_q <= ge ? diff[31:0] : shifted[31:0];
      quo_q <= {quo_q[30:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

FILE: sv/wse_datapath.sv
// Datapath: sample capture, multipliers, shared divider, history rings,
// averaging, duty ramp, configuration registers and output register.
// Depends on wse_pkg and wse_div.
`default_nettype none

module wse_datapath
  import wse_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire cmd_t                cmd_i,
  output status_t                  status_o,
  input  wire in_t                 in_data_i,
  input  wire logic                cfg_valid_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                out_ready_i,
  output logic                     out_valid_o,
  output out_t                     out_data_o
);

  logic [15:0] dpt_q, duty_max_q, duty_q;
  logic [7:0]  period_q, step_q, rc_q;

  logic [31:0] cnt_q  [Wheels];
  logic [31:0] prev_q [Wheels];
  logic [31:0] hist_q [Wheels][AvgTaps];
  logic signed [31:0] avg_q [Wheels];
  logic [31:0] prev_time_q, dt_q, prod1_q, prod2_q;
  logic        zero_q;
  logic [WheelW-1:0] w_q;
  logic [SlotW-1:0]  slot_q;
  logic        out_valid_q;
  out_t        out_q;

  logic [31:0] delta;
  logic [47:0] m1_full;
  logic [41:0] m2_full;
  logic        div_done;
  logic [31:0] quotient;
  logic signed [33:0] sum [Wheels];
  logic signed [32:0] rear_sum;
  logic [16:0] duty_sum;
  logic [15:0] duty_next;
  logic [7:0]  period_eff, rc_next;
  logic [8:0]  rc_inc;

  wse_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (prod2_q),
    .divisor_i  (dt_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_comb begin
    delta   = cnt_q[w_q] - prev_q[w_q];
    m1_full = delta * dpt_q;
    m2_full = prod1_q * MsW'(MsPerS);
    for (int w = 0; w < Wheels; w++) begin
      sum[w] = '0;
      for (int k = 0; k < AvgTaps; k++) begin
        sum[w] = sum[w] + 34'(signed'(hist_q[w][k]));
      end
    end
    rear_sum = 33'(avg_q[2]) + 33'(avg_q[3]);
    duty_sum = {1'b0, duty_q} + {9'd0, step_q};
    if (rc_q != '0) begin
      duty_next = duty_q;
    end else if (duty_q >= duty_max_q) begin
      duty_next = '0;
    end else begin
      duty_next = duty_sum[16] ? 16'hFFFF : duty_sum[15:0];
    end
    period_eff = (period_q == '0) ? 8'd1 : period_q;
    rc_inc     = {1'b0, rc_q} + 9'd1;
    rc_next    = (rc_inc >= {1'b0, period_eff}) ? 8'd0 : rc_inc[7:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dpt_q       <= 16'd1;
      period_q    <= 8'd30;
      step_q      <= 8'd5;
      duty_max_q  <= 16'd100;
      duty_q      <= '0;
      rc_q        <= '0;
      prev_time_q <= '0;
      slot_q      <= '0;
      w_q         <= '0;
      out_valid_q <= 1'b0;
      for (int w = 0; w < Wheels; w++) begin
        prev_q[w] <= '0;
        for (int k = 0; k < AvgTaps; k++) begin
          hist_q[w][k] <= '0;
        end
      end
    end else begin
      if (cfg_valid_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_DIST_PER_TICK: dpt_q      <= cfg_data_i;
          CFG_RAMP_PERIOD:   period_q   <= cfg_data_i[7:0];
          CFG_RAMP_STEP:     step_q     <= cfg_data_i[7:0];
          CFG_DUTY_MAX:      duty_max_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.load) begin
        prev_time_q <= in_data_i.time_ms;
        w_q         <= '0;
      end
      if (cmd_i.next_wheel) begin
        w_q <= w_q + WheelW'(1);
      end
      if (cmd_i.store) begin
        hist_q[w_q][slot_q] <= zero_q ? 32'hFFFF_FFFF : quotient;
        prev_q[w_q]         <= cnt_q[w_q];
      end
      if (cmd_i.finish) begin
        duty_q      <= duty_next;
        rc_q        <= rc_next;
        slot_q      <= slot_q + SlotW'(1);
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cnt_q[0] <= in_data_i.front_left_count;
      cnt_q[1] <= in_data_i.front_right_count;
      cnt_q[2] <= in_data_i.rear_left_count;
      cnt_q[3] <= in_data_i.rear_right_count;
      dt_q     <= in_data_i.time_ms - prev_time_q;
      zero_q   <= (in_data_i.time_ms == prev_time_q);
    end
    if (cmd_i.mul1) begin
      prod1_q <= m1_full[31:0];
    end
    if (cmd_i.mul2) begin
      prod2_q <= m2_full[31:0];
    end
    if (cmd_i.avg) begin
      for (int w = 0; w < Wheels; w++) begin
        avg_q[w] <= sum[w][33:2];
      end
    end
    if (cmd_i.finish) begin
      out_q.front_left_speed  <= avg_q[0];
      out_q.front_right_speed <= avg_q[1];
      out_q.rear_left_speed   <= avg_q[2];
      out_q.rear_right_speed  <= avg_q[3];
      out_q.vehicle_speed     <= rear_sum[32:1];
      out_q.duty_out          <= duty_q;
      out_q.div_zero          <= zero_q;
    end
  end

  always_comb begin
    status_o.zero       = zero_q;
    status_o.last_wheel = (w_q == WheelW'(Wheels - 1));
    status_o.div_done   = div_done;
    status_o.out_free   = !out_valid_q || out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

FILE: sv/wse_ctrl.sv
// Controller state machine: sequences the four wheels through multiply,
// divide and store, then averaging and result hand-off. Depends on wse_pkg.
`default_nettype none

module wse_ctrl
  import wse_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire status_t status_i,
  output cmd_t         cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_MUL1;
        end
      end
      ST_MUL1: begin
        cmd_o.mul1 = 1'b1;
        state_d    = ST_MUL2;
      end
      ST_MUL2: begin
        cmd_o.mul2 = 1'b1;
        state_d    = status_i.zero ? ST_STORE : ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_WAIT;
      end
      ST_WAIT: begin
        if (status_i.div_done) begin
          state_d = ST_STORE;
        end
      end
      ST_STORE: begin
        cmd_o.store = 1'b1;
        if (status_i.last_wheel) begin
          state_d = ST_AVG;
        end else begin
          cmd_o.next_wheel = 1'b1;
          state_d          = ST_MUL1;
        end
      end
      ST_AVG: begin
        cmd_o.avg = 1'b1;
        state_d   = ST_FINISH;
      end
      ST_FINISH: begin
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: sv/wse_checker.sv
// Port-level checks for the wheel speed estimator, bound to the top level.
// Depends on wse_pkg.
`default_nettype none

module wse_checker
  import wse_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_ready_o,
  input wire in_t                 in_data_i,
  input wire logic                out_valid_o,
  input wire logic                out_ready_i,
  input wire out_t                out_data_o,
  input wire logic                cfg_valid_i,
  input wire logic                cfg_ready_o,
  input wire logic [CfgIdxW-1:0]  cfg_index_i,
  input wire logic [CfgDataW-1:0] cfg_data_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed or dropped while stalled");

  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while a sample is in progress");

  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !$rose(out_valid_o))
    else $error("result appeared one cycle after input transfer");

  a_ready_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_ready_o)
    else $error("result issued without returning to idle");

endmodule

bind wheel_speed_estimator_pwm_ramp wse_checker u_wse_checker (.*);

`default_nettype wire

FILE: dv/wheel_speed_estimator_pwm_ramp_test.sv
// Testbench for wheel_speed_estimator_pwm_ramp: directed and random samples with register
// phases, checked against an in-bench speed and duty ramp predictor.
// Depends on wse_pkg and the wheel_speed_estimator_pwm_ramp RTL.
module wheel_speed_estimator_pwm_ramp_test;
  import wse_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CfgIdxW-1:0] CFG_SPARE_IDX = 8'd4;
  localparam logic [CfgIdxW-1:0] CFG_LAST_IDX  = 8'hFF;
  localparam int unsigned        SettleCycles  = 200;
  localparam int unsigned        MaxPrinted    = 100;

  typedef struct packed {
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] val;
  } reg_write_t;

  logic                clk;
  logic                rst_n       = 1'b0;
  logic                in_valid    = 1'b0;
  in_t                 in_data     = '0;
  logic                out_ready   = 1'b0;
  logic                cfg_valid   = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index   = '0;
  logic [CfgDataW-1:0] cfg_data    = '0;
  logic                in_ready_o;
  logic                out_valid_o;
  out_t                out_data_o;
  logic                cfg_ready_o;

  in_t        sample_q [$];
  out_t       speed_q  [$];
  reg_write_t reg_q    [$];
  int         gap_pct    = 22;
  int         mismatches = 0;

  // predictor state and registers
  logic [31:0]        last_count [Wheels];
  logic [31:0]        last_stamp;
  logic signed [31:0] ring [Wheels][AvgTaps];
  logic [SlotW-1:0]   ring_pos;
  logic [15:0]        duty;
  logic [7:0]         ramp_ctr;
  logic [15:0]        mm_per_tick;
  logic [7:0]         ramp_len;
  logic [7:0]         ramp_inc;
  logic [15:0]        duty_top;

  // sample generator state
  logic [31:0] track_count [Wheels];
  logic [31:0] track_stamp;

  wheel_speed_estimator_pwm_ramp u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (mismatches < MaxPrinted) begin
      $display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
    end
    mismatches++;
  endtask

  task automatic clear_speed_model();
    for (int w = 0; w < Wheels; w++) begin
      last_count[w]  = '0;
      track_count[w] = '0;
      for (int k = 0; k < AvgTaps; k++) begin
        ring[w][k] = '0;
      end
    end
    last_stamp  = '0;
    track_stamp = '0;
    ring_pos    = '0;
    duty        = '0;
    ramp_ctr    = '0;
    mm_per_tick = 16'd1;
    ramp_len    = 8'd30;
    ramp_inc    = 8'd5;
    duty_top    = 16'd100;
  endtask

  function automatic void apply_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    case (idx)
      CFG_DIST_PER_TICK: mm_per_tick = val;
      CFG_RAMP_PERIOD:   ramp_len    = val[7:0];
      CFG_RAMP_STEP:     ramp_inc    = val[7:0];
      CFG_DUTY_MAX:      duty_top    = val;
      default: ;
    endcase
  endfunction

  function automatic out_t predict_speeds(in_t s);
    logic [31:0]        cnt [Wheels];
    logic [31:0]        elapsed;
    logic [31:0]        travel;
    logic signed [33:0] acc;
    logic signed [31:0] avg [Wheels];
    logic signed [32:0] rear;
    logic [16:0]        raised;
    logic [8:0]         next_ctr;
    logic [7:0]         period;
    out_t               r;
    cnt[0] = s.front_left_count;
    cnt[1] = s.front_right_count;
    cnt[2] = s.rear_left_count;
    cnt[3] = s.rear_right_count;
    elapsed    = s.time_ms - last_stamp;
    last_stamp = s.time_ms;
    for (int w = 0; w < Wheels; w++) begin
      travel        = (cnt[w] - last_count[w]) * {16'd0, mm_per_tick};
      last_count[w] = cnt[w];
      ring[w][ring_pos] = (elapsed == 0) ? 32'hFFFF_FFFF : (travel * MsPerS) / elapsed;
      acc = '0;
      for (int k = 0; k < AvgTaps; k++) begin
        acc = acc + ring[w][k];
      end
      avg[w] = 32'(acc >>> 2);
    end
    ring_pos = ring_pos + 1'b1;
    rear     = avg[2] + avg[3];
    r.front_left_speed  = avg[0];
    r.front_right_speed = avg[1];
    r.rear_left_speed   = avg[2];
    r.rear_right_speed  = avg[3];
    r.vehicle_speed     = 32'(rear >>> 1);
    r.duty_out          = duty;
    r.div_zero          = (elapsed == 0);
    if (ramp_ctr == 0) begin
      if (duty >= duty_top) begin
        duty = '0;
      end else begin
        raised = duty + ramp_inc;
        duty   = raised[16] ? 16'hFFFF : raised[15:0];
      end
    end
    period   = (ramp_len == 0) ? 8'd1 : ramp_len;
    next_ctr = ramp_ctr + 9'd1;
    ramp_ctr = (next_ctr >= period) ? 8'd0 : next_ctr[7:0];
    return r;
  endfunction

  function automatic in_t make_sample(logic [31:0] fl, logic [31:0] fr, logic [31:0] rl,
                                      logic [31:0] rr, logic [31:0] stamp);
    in_t s;
    s.front_left_count  = fl;
    s.front_right_count = fr;
    s.rear_left_count   = rl;
    s.rear_right_count  = rr;
    s.time_ms           = stamp;
    return s;
  endfunction

  // mostly plausible motion with small deltas, some pure noise
  function automatic in_t next_sample();
    if ($urandom_range(99) < 20) begin
      for (int w = 0; w < Wheels; w++) begin
        track_count[w] = $urandom;
      end
      track_stamp = $urandom;
    end else begin
      for (int w = 0; w < Wheels; w++) begin
        if ($urandom_range(9) == 0) begin
          track_count[w] = track_count[w] - $urandom_range(0, 500);
        end else begin
          track_count[w] = track_count[w] + $urandom_range(0, 3000);
        end
      end
      track_stamp = track_stamp + (($urandom_range(19) == 0) ? 0 : $urandom_range(1, 40));
    end
    return make_sample(track_count[0], track_count[1], track_count[2], track_count[3],
                       track_stamp);
  endfunction

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    reg_write_t wr;
    wr.idx = idx;
    wr.val = val;
    reg_q.push_back(wr);
  endtask

  task automatic flush_regs();
    while (reg_q.size() != 0 || cfg_valid) @(posedge clk);
  endtask

  task automatic drain_samples();
    while (sample_q.size() != 0 || in_valid || speed_q.size() != 0) @(posedge clk);
  endtask

  task automatic queue_random(int count);
    for (int i = 0; i < count; i++) begin
      sample_q.push_back(next_sample());
    end
  endtask

  // sample driver
  always @(posedge clk) begin
    in_t s;
    if (rst_n) begin
      if (in_valid && in_ready_o) begin
        speed_q.push_back(predict_speeds(in_data));
      end
      if (!in_valid || in_ready_o) begin
        if (sample_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
          s = sample_q.pop_front();
          in_valid <= 1'b1;
          in_data  <= s;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // register driver
  always @(posedge clk) begin
    reg_write_t wr;
    if (rst_n) begin
      if (cfg_valid && cfg_ready_o) begin
        apply_reg(cfg_index, cfg_data);
      end
      if (!cfg_valid || cfg_ready_o) begin
        if (reg_q.size() != 0) begin
          wr = reg_q.pop_front();
          cfg_valid <= 1'b1;
          cfg_index <= wr.idx;
          cfg_data  <= wr.val;
        end else begin
          cfg_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    out_t want;
    if (rst_n) begin
      if (out_valid_o && out_ready) begin
        if (speed_q.size() == 0) begin
          report_mismatch("unexpected transfer", 32'(out_data_o.vehicle_speed), '0);
        end else begin
          want = speed_q.pop_front();
          if (out_data_o.front_left_speed !== want.front_left_speed)
            report_mismatch("front_left_speed", out_data_o.front_left_speed,
                            want.front_left_speed);
          if (out_data_o.front_right_speed !== want.front_right_speed)
            report_mismatch("front_right_speed", out_data_o.front_right_speed,
                            want.front_right_speed);
          if (out_data_o.rear_left_speed !== want.rear_left_speed)
            report_mismatch("rear_left_speed", out_data_o.rear_left_speed,
                            want.rear_left_speed);
          if (out_data_o.rear_right_speed !== want.rear_right_speed)
            report_mismatch("rear_right_speed", out_data_o.rear_right_speed,
                            want.rear_right_speed);
          if (out_data_o.vehicle_speed !== want.vehicle_speed)
            report_mismatch("vehicle_speed", out_data_o.vehicle_speed, want.vehicle_speed);
          if (out_data_o.duty_out !== want.duty_out)
            report_mismatch("duty_out", 32'(out_data_o.duty_out), 32'(want.duty_out));
          if (out_data_o.div_zero !== want.div_zero)
            report_mismatch("div_zero", 32'(out_data_o.div_zero), 32'(want.div_zero));
        end
      end
      out_ready <= ($urandom_range(99) >= gap_pct);
    end
  end

  initial begin
    clear_speed_model();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // default registers: zero elapsed time, counter and timestamp wrap
    sample_q.push_back(make_sample(0, 0, 0, 0, 0));
    sample_q.push_back(make_sample('1, 1, 32'h8000_0000, 32'h7FFF_FFFF, 1));
    sample_q.push_back(make_sample(0, 1, 32'h8000_0000, 32'h7FFF_FFFF, '1));
    sample_q.push_back(make_sample(0, 1, 32'h8000_0000, 32'h7FFF_FFFF, '1));
    sample_q.push_back(make_sample(5, 7, 8, 9, 0));
    sample_q.push_back(make_sample(1000, 2000, 3000, 4000, 1000));
    sample_q.push_back(make_sample(32'hDEAD_BEEF, 32'h1234_5678, 32'hFFFF_0000,
                                   32'h0000_FFFF, 32'h8000_0000));
    sample_q.push_back(make_sample(32'hDEAD_BEEF, 32'h1234_5678, 32'hFFFF_0000,
                                   32'h0000_FFFF, 32'h8000_0000));
    drain_samples();

    // widest distance, period zero via masked data, largest step, spare indexes
    write_reg(CFG_DIST_PER_TICK, 16'hFFFF);
    write_reg(CFG_RAMP_PERIOD, 16'hFF00);
    write_reg(CFG_RAMP_STEP, 16'hFFFF);
    write_reg(CFG_DUTY_MAX, 16'hFFFF);
    write_reg(CFG_SPARE_IDX, 16'hFFFF);
    write_reg(CFG_LAST_IDX, 16'h0000);
    flush_regs();
    sample_q.push_back(make_sample('1, '1, '1, '1, 32'h8000_0001));
    sample_q.push_back(make_sample(0, 0, 0, 0, 32'h8000_0002));
    sample_q.push_back(make_sample(0, 0, 0, 0, 32'h8000_0002));
    sample_q.push_back(make_sample(32'h8000_0000, 32'h0000_0001, 32'h7FFF_FFFF,
                                   32'hFFFF_FFFE, 32'h8000_0005));
    sample_q.push_back(make_sample(32'h8000_0001, 32'h0000_0000, 32'h8000_0000,
                                   32'hFFFF_FFFF, 32'h8000_0004));
    sample_q.push_back(make_sample($urandom, $urandom, $urandom, $urandom, $urandom));
    drain_samples();

    // long run with no idling; the duty ramp reaches saturation here
    gap_pct = 0;
    write_reg(CFG_DIST_PER_TICK, 16'h0000);
    write_reg(CFG_RAMP_PERIOD, 16'd1);
    write_reg(CFG_RAMP_STEP, 16'd254);
    flush_regs();
    track_stamp = $urandom;
    queue_random(300);
    drain_samples();

    gap_pct = 22;
    write_reg(CFG_DIST_PER_TICK, 16'($urandom_range(2, 65534)));
    write_reg(CFG_RAMP_PERIOD, 16'd255);
    write_reg(CFG_RAMP_STEP, 16'd0);
    write_reg(CFG_DUTY_MAX, 16'd0);
    flush_regs();
    queue_random(150);
    drain_samples();

    // shrink the period below the running count
    write_reg(CFG_DIST_PER_TICK, 16'd1);
    write_reg(CFG_RAMP_PERIOD, 16'd7);
    write_reg(CFG_RAMP_STEP, 16'($urandom_range(1, 255)));
    write_reg(CFG_DUTY_MAX, 16'($urandom_range(1, 2000)));
    flush_regs();
    queue_random(150);
    drain_samples();

    repeat (SettleCycles) @(posedge clk);
    if (speed_q.size() != 0) begin
      report_mismatch("results never returned", 32'(speed_q.size()), '0);
    end
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
